@@ design/binary_closing_5x5_defines.svh @@
`ifndef BINARY_CLOSING_5X5_DEFINES_SVH
`define BINARY_CLOSING_5X5_DEFINES_SVH

// Assertion helpers. They expect clk and arst_n to be visible where they are used.

// The consequent must hold in the same cycle as the antecedent.
`define BCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bcl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bcl_pkg;

	localparam int FW_W = 10;
	localparam int FH_W = 9;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = FW_W'(500);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(200);

	typedef logic [1:0] settle_t;

endpackage

`default_nettype wire

@@ design/bcl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pixel input channel.
interface bcl_pix_if;
	logic valid;
	logic ready;
	logic occupied;
	logic drain;
	modport source(output valid, output occupied, output drain, input ready);
	modport sink(input valid, input occupied, input drain, output ready);
endinterface

// Closed pixel output channel.
interface bcl_res_if;
	logic valid;
	logic ready;
	logic closed_value;
	logic frame_end;
	modport source(output valid, output closed_value, output frame_end, input ready);
	modport sink(input valid, input closed_value, input frame_end, output ready);
endinterface

// Register write channel.
interface bcl_cfg_if;
	logic valid;
	logic ready;
	logic [bcl_pkg::CFG_IDX_W-1:0] index;
	logic [bcl_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/binary_closing_5x5.sv @@
// Streaming binary closing (dilation then erosion) with a square kernel over a raster frame.
// A result passes through stage one and then the output register; the closed pixel at raster
// position p leaves with the item that brings p + 2*(R*W + R). Throughput: one item per clock
// unless the output stalls, set by one read-modify-write per item on each line memory. Reset
// clears counters and valid flags and sets the frame size to 500 x 200; the line memories are
// not cleared. After reset or any register write, input ready is low until settle_q is zero.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_closing_5x5_defines.svh"

module binary_closing_5x5 #(
	parameter int MAX_WIDTH = 512,
	parameter int KERNEL_SIZE = 5
) (
	input wire clk,
	input wire arst_n,
	bcl_pix_if.sink pixel,
	bcl_res_if.source result,
	bcl_cfg_if.sink cfg
);
	import bcl_pkg::*;

	localparam int R = KERNEL_SIZE / 2;
	localparam int SPAN = 2 * R + 1;
	localparam int SW = SPAN - 1;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > FW_W) ? WW : FW_W;
	localparam int CW = WW + 1;
	localparam int PW = WW + FH_W;
	localparam int TW = WW + FH_W + 1;
	localparam int RSW = $clog2(SPAN);

	typedef struct packed {
		logic pix;
		logic has_d;
		logic d_in;
		logic has_e;
		logic e_last;
		logic [AW-1:0] col;
		logic [SW-1:0] rmask;
		logic [AW-1:0] dcol;
		logic [SW-1:0] dmask;
		logic [SPAN-1:0] dslot;
		logic [SPAN-1:0] eslot;
	} item_t;

	// Window slots that lie in the same row as the centre column.
	function automatic logic [SPAN-1:0] slot_mask(input logic [AW-1:0] cc,
			input logic [WW-1:0] w);
		logic [CW-1:0] ccr;
		logic [SPAN-1:0] m;
		ccr = CW'(cc) + CW'(R);
		for (int k = 0; k < SPAN; k++) begin
			m[k] = (ccr >= CW'(k)) && ((ccr - CW'(k)) < CW'(w));
		end
		return m;
	endfunction

	// Rows above the top of the frame are masked out of the stored column.
	function automatic logic [SW-1:0] row_mask(input logic [RSW-1:0] r);
		logic [SW-1:0] m;
		for (int i = 0; i < SW; i++) begin
			m[i] = (int'(r) > i);
		end
		return m;
	endfunction

	function automatic logic [AW:0] col_step(input logic [AW-1:0] c, input logic [WW-1:0] w);
		logic wrap;
		wrap = (WW'(c) + WW'(1)) == w;
		return wrap ? {1'b1, AW'(0)} : {1'b0, c + AW'(1)};
	endfunction

	function automatic logic [RSW-1:0] row_step(input logic [RSW-1:0] r, input logic wrap);
		return (wrap && r != RSW'(SW)) ? r + RSW'(1) : r;
	endfunction

	// Configuration.
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic cfg_fire;
	logic cfg_restart;
	settle_t settle_q;

	assign cfg.ready = 1'b1;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign cfg_restart = cfg_fire &&
		(cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			settle_q <= 2'b11;
		end else begin
			settle_q <= cfg_fire ? 2'b11 : {1'b0, settle_q[1]};
			if (cfg_fire) begin
				unique case (cfg.index)
					REG_FRAME_WIDTH: frame_width_q <= cfg.data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg.data[FH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	logic [EW-1:0] width_ext;
	logic [WW-1:0] eff_w;
	logic [FH_W-1:0] eff_h;
	logic [PW-1:0] area;

	always_comb begin
		width_ext = EW'(frame_width_q);
		if (width_ext == '0) begin
			eff_w = WW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_ext);
		end
		eff_h = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
		area = PW'(eff_w) * PW'(eff_h);
	end

	// Frame thresholds, up to two register levels behind the size registers.
	logic [TW-1:0] total_q, lag_q, dlim_q, elim_q, last_q;

	always_ff @(posedge clk) begin
		total_q <= TW'(area);
		lag_q <= TW'(eff_w) * TW'(R) + TW'(R);
		dlim_q <= total_q + lag_q;
		elim_q <= lag_q + lag_q;
		last_q <= total_q + lag_q + lag_q - TW'(1);
	end

	// Position counters: t is the raster position taken in, d trails it by one lag
	// (dilation centre), e by two lags (erosion centre).
	logic [TW-1:0] t_q, t_e;
	logic [AW-1:0] col_q, dcol_q, ecol_q, col_e, dcol_e, ecol_e;
	logic [RSW-1:0] row_q, drow_q, row_e, drow_e;
	logic [AW:0] cstep, dstep, estep;

	logic acc, past_end, fresh, work;
	logic has_d, d_in, has_e, e_last;
	logic valid_s1, go_s1, proc;
	item_t item_s1;
	logic out_valid_q, closed_q, end_q;

	assign acc = pixel.valid && pixel.ready;
	assign past_end = t_q >= total_q;
	assign fresh = !pixel.drain && past_end;
	assign work = acc && (!pixel.drain || past_end);
	assign has_d = !fresh && (t_q >= lag_q);
	assign d_in = t_q < dlim_q;
	assign has_e = !fresh && (t_q >= elim_q);
	assign e_last = t_q == last_q;

	always_comb begin
		t_e = fresh ? '0 : t_q;
		col_e = fresh ? '0 : col_q;
		row_e = fresh ? '0 : row_q;
		dcol_e = fresh ? '0 : dcol_q;
		drow_e = fresh ? '0 : drow_q;
		ecol_e = fresh ? '0 : ecol_q;
		cstep = col_step(col_e, eff_w);
		dstep = col_step(dcol_e, eff_w);
		estep = col_step(ecol_e, eff_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			col_q <= '0;
			row_q <= '0;
			dcol_q <= '0;
			drow_q <= '0;
			ecol_q <= '0;
		end else if (cfg_restart || (work && has_e && e_last)) begin
			t_q <= '0;
			col_q <= '0;
			row_q <= '0;
			dcol_q <= '0;
			drow_q <= '0;
			ecol_q <= '0;
		end else if (work) begin
			t_q <= t_e + TW'(1);
			col_q <= cstep[AW-1:0];
			row_q <= row_step(row_e, cstep[AW]);
			dcol_q <= has_d ? dstep[AW-1:0] : dcol_e;
			drow_q <= has_d ? row_step(drow_e, dstep[AW]) : drow_e;
			ecol_q <= has_e ? estep[AW-1:0] : ecol_e;
		end
	end

	// Stage one holds an item, with its line memory reads, while the output register is full and not taken.
	assign go_s1 = !item_s1.has_e || !out_valid_q || result.ready;
	assign proc = valid_s1 && go_s1;
	assign pixel.ready = (settle_q == '0) && (!valid_s1 || go_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (work) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			item_s1.pix <= pixel.occupied && !pixel.drain;
			item_s1.has_d <= has_d;
			item_s1.d_in <= d_in;
			item_s1.has_e <= has_e;
			item_s1.e_last <= e_last;
			item_s1.col <= col_e;
			item_s1.rmask <= row_mask(row_e);
			item_s1.dcol <= dcol_e;
			item_s1.dmask <= row_mask(drow_e);
			item_s1.dslot <= slot_mask(dcol_e, eff_w);
			item_s1.eslot <= slot_mask(ecol_e, eff_w);
		end
	end

	// Line memories: per column, the previous SPAN-1 rows of raw and dilated pixels.
	logic [SW-1:0] raw_mem [MAX_WIDTH];
	logic [SW-1:0] dil_mem [MAX_WIDTH];
	logic [SW-1:0] raw_rd_s1, dil_rd_s1;
	logic [SPAN-1:0] raw_vec, dil_vec;

	always_ff @(posedge clk) begin
		if (work) begin
			raw_rd_s1 <= raw_mem[col_e];
			dil_rd_s1 <= dil_mem[dcol_e];
		end
		if (proc) begin
			raw_mem[item_s1.col] <= raw_vec[SW-1:0];
		end
		if (proc && item_s1.has_d) begin
			dil_mem[item_s1.dcol] <= dil_vec[SW-1:0];
		end
	end

	// The latest write to each memory is kept so that a read issued in the same
	// cycle as that write still sees the new column.
	logic raw_lw_vld_q, dil_lw_vld_q;
	logic [AW-1:0] raw_lw_col_q, dil_lw_col_q;
	logic [SW-1:0] raw_lw_data_q, dil_lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_lw_vld_q <= 1'b0;
			dil_lw_vld_q <= 1'b0;
		end else begin
			if (proc) begin
				raw_lw_vld_q <= 1'b1;
			end
			if (proc && item_s1.has_d) begin
				dil_lw_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			raw_lw_col_q <= item_s1.col;
			raw_lw_data_q <= raw_vec[SW-1:0];
		end
		if (proc && item_s1.has_d) begin
			dil_lw_col_q <= item_s1.dcol;
			dil_lw_data_q <= dil_vec[SW-1:0];
		end
	end

	// Sliding windows, slot 0 is the newest column.
	logic [SPAN-1:0] raw_win_q [SPAN];
	logic [SPAN-1:0] dil_win_q [SPAN];
	logic [SPAN-1:0] raw_win_n [SPAN];
	logic [SPAN-1:0] dil_win_n [SPAN];
	logic [SW-1:0] raw_old, dil_old;
	logic dbit, ebit;

	always_comb begin
		raw_old = (raw_lw_vld_q && raw_lw_col_q == item_s1.col) ? raw_lw_data_q : raw_rd_s1;
		raw_vec = {raw_old & item_s1.rmask, item_s1.pix};
		raw_win_n[0] = raw_vec;
		for (int k = 1; k < SPAN; k++) begin
			raw_win_n[k] = raw_win_q[k-1];
		end
		// Below the frame the dilated value is taken as set so the erosion ignores it.
		dbit = !item_s1.d_in;
		for (int k = 0; k < SPAN; k++) begin
			dbit = dbit | (item_s1.dslot[k] & (|raw_win_n[k]));
		end

		dil_old = (dil_lw_vld_q && dil_lw_col_q == item_s1.dcol) ? dil_lw_data_q : dil_rd_s1;
		dil_vec = {(dil_old & item_s1.dmask) | ~item_s1.dmask, dbit};
		dil_win_n[0] = dil_vec;
		for (int k = 1; k < SPAN; k++) begin
			dil_win_n[k] = dil_win_q[k-1];
		end
		ebit = 1'b1;
		for (int k = 0; k < SPAN; k++) begin
			ebit = ebit & (!item_s1.eslot[k] | (&dil_win_n[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			raw_win_q <= raw_win_n;
		end
		if (proc && item_s1.has_d) begin
			dil_win_q <= dil_win_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && item_s1.has_e) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && item_s1.has_e) begin
			closed_q <= ebit;
			end_q <= item_s1.e_last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.closed_value = closed_q;
	assign result.frame_end = end_q;

	`BCL_ASSERT_IMP(a_stall_blocks_input, valid_s1 && !go_s1, !pixel.ready, "item taken in a stall")
	`BCL_ASSERT_IMP(a_col_in_row, 1'b1, WW'(col_q) < eff_w, "input column outside the frame row")
	`BCL_ASSERT_NXT(a_last_restarts, work && has_e && e_last, t_q == '0, "frame did not restart")

endmodule

`default_nettype wire
